// ----- design/nhse_pkg.sv -----
`default_nettype none

package nhse_pkg;

    // Q16.16 value
    typedef logic signed [31:0] q_t;

    // one operand of each of the three pairs of one lane
    typedef q_t vec3_t [3];

    localparam q_t Q_MAX = 32'sh7fff_ffff;
    localparam q_t Q_MIN = 32'sh8000_0000;
    localparam q_t Q_ZERO = 32'sh0000_0000;
    localparam q_t Q_THREE = 32'sh0003_0000;
    localparam logic [30:0] Q_ONE_U = 31'h0001_0000;

    // round(ln 2 * 2^32)
    localparam logic [32:0] LN2_Q32 = 33'd2977044472;

    // configuration register indexes
    localparam logic [1:0] REG_LAME_LAMBDA = 2'd0;
    localparam logic [1:0] REG_SHEAR_MODULUS = 2'd1;

    // unit latencies in enabled cycles
    localparam int unsigned LANE_LAT = 2;
    localparam int unsigned LOG_LAT = 20;
    localparam int unsigned DIV_LAT = 34;

    // saturate a wide sum to 32 bits
    function automatic q_t sat_q(input logic signed [35:0] v);
        if (v > 36'sh0_7fff_ffff) begin
            return Q_MAX;
        end else if (v < 36'shf_8000_0000) begin
            return Q_MIN;
        end
        return q_t'(v[31:0]);
    endfunction

    // product shifted by 16, rounded half away from zero, saturated
    function automatic q_t qmul_round(input logic signed [63:0] p);
        logic        neg;
        logic [63:0] mag;
        logic [47:0] sh;
        neg = p[63];
        mag = neg ? 64'(-p) : 64'(p);
        mag = mag + 64'h8000;
        sh = mag[63:16];
        if (!neg && sh > 48'h0000_7fff_ffff) begin
            return Q_MAX;
        end else if (neg && sh > 48'h0000_8000_0000) begin
            return Q_MIN;
        end
        return neg ? q_t'(32'd0 - sh[31:0]) : q_t'(sh[31:0]);
    endfunction

    // halve, rounding half away from zero
    function automatic q_t half_rnd(input q_t v);
        logic        neg;
        logic [32:0] mag;
        neg = v[31];
        mag = neg ? 33'd0 - 33'(v) : 33'(v);
        mag = mag + 33'd1;
        return neg ? q_t'(32'd0 - mag[32:1]) : q_t'(mag[32:1]);
    endfunction

endpackage

`default_nettype wire

// ----- design/neohookean_stress_energy.sv -----
// Compressible neo-Hookean stress unit. Each word on the s_ side is one 3x3
// deformation gradient F in signed Q16.16; each word on the m_ side is the
// first Piola stress P = F*S (row-major) and the strain energy density, with
// m_tuser set and all results zero when det(F^T F) is not positive. The unit
// is fully pipelined: it takes one word per cycle unless a finished word is
// held at the output, its depth set mostly by the nine parallel 32-step
// dividers that form C^-1 and, alongside them, the 16-step squaring logarithm.
// Results come out in input order. lame_lambda (index 0) and shear_modulus
// (index 1), unsigned Q15.16 and 1.0 after reset, must be written through
// cfg_wr_en/cfg_index/cfg_wr_data only while the unit is idle; it does not enforce this.
`default_nettype none

module neohookean_stress_energy (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [287:0] s_tdata,    // f_00, f_01, f_02, f_10, ..., f_22
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [319:0] m_tdata,    // stress_00, ..., stress_22, strain_energy
    output logic         m_tuser,    // invalid
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wr_data
);
    import nhse_pkg::*;

    // stage at which each value is ready
    localparam int unsigned ST_F = 1;
    localparam int unsigned ST_C = ST_F + LANE_LAT;
    localparam int unsigned ST_TR = ST_C + 1;
    localparam int unsigned ST_COF = ST_C + LANE_LAT;
    localparam int unsigned ST_DET = ST_COF + LANE_LAT;
    localparam int unsigned ST_LN = ST_DET + LOG_LAT;
    localparam int unsigned ST_P = ST_LN + LANE_LAT;
    localparam int unsigned ST_COEF = ST_P + 1;
    localparam int unsigned ST_W = ST_COEF + LANE_LAT;
    localparam int unsigned ST_CI = ST_DET + DIV_LAT;
    localparam int unsigned ST_S = ST_CI + LANE_LAT;
    localparam int unsigned ST_PK = ST_S + LANE_LAT;

    localparam int unsigned D_C0 = ST_COF - ST_C;
    localparam int unsigned D_COF = ST_DET - ST_COF;
    localparam int unsigned D_INV = ST_PK - ST_DET;
    localparam int unsigned D_LN = ST_COEF - ST_LN;
    localparam int unsigned D_TR = ST_COEF - ST_TR;
    localparam int unsigned D_W = ST_PK - ST_W;
    localparam int unsigned D_COEF = ST_CI - ST_COEF;
    localparam int unsigned D_F = ST_S - ST_F;

    logic         en;
    logic [30:0]  lambda_reg;
    logic [30:0]  mu_reg;
    q_t           lambda_q;
    q_t           mu_q;
    q_t           half_mu;
    logic [ST_PK:1] vld_reg;
    logic         out_valid_reg;
    logic [319:0] out_data_reg;
    logic         out_inv_reg;

    q_t           f_reg [9];
    q_t           c_mat [9];
    q_t           cof_mat [9];
    q_t           ci_mat [9];
    q_t           s_mat [9];
    q_t           p_mat [9];
    q_t           det;
    q_t           lnj;
    q_t           p_val;
    q_t           w_val;
    q_t           trc;
    q_t           trm3_reg;
    q_t           coef_reg;
    q_t           hp_mu_reg;
    logic         det_bad;

    logic [95:0]  c0_dly_reg [D_C0];
    logic [287:0] cof_dly_reg [D_COF];
    logic [D_INV-1:0] inv_dly_reg;
    q_t           lnj_dly_reg [D_LN];
    q_t           trm3_dly_reg [D_TR];
    q_t           w_dly_reg [D_W];
    q_t           coef_dly_reg [D_COEF];
    logic [287:0] f_dly_reg [D_F];
    logic [287:0] f_flat;
    logic [287:0] cof_flat;
    logic [287:0] f_old;
    logic [287:0] cof_old;

    // the whole pipeline advances unless a finished word is held
    assign en = !out_valid_reg || m_tready;
    assign s_tready = en;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lambda_reg <= Q_ONE_U;
            mu_reg <= Q_ONE_U;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_LAME_LAMBDA: lambda_reg <= cfg_wr_data;
                REG_SHEAR_MODULUS: mu_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    assign lambda_q = q_t'({1'b0, lambda_reg});
    assign mu_q = q_t'({1'b0, mu_reg});
    assign half_mu = half_rnd(mu_q);

    // valid bits follow the words down the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= {vld_reg[ST_PK-1:1], s_tvalid};
            out_valid_reg <= vld_reg[ST_PK];
        end
    end

    // capture F
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                f_reg[i] <= q_t'(s_tdata[32*i +: 32]);
            end
        end
    end

    // C = F^T F, one lane per element
    for (genvar gi = 0; gi < 3; gi++) begin : g_c_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_c_col
            vec3_t la;
            vec3_t lb;
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign la[k] = f_reg[3*k + gi];
                assign lb[k] = f_reg[3*k + gj];
            end
            nhse_dot_lane u_lane (
                .aclk   (aclk),
                .en     (en),
                .a      (la),
                .b      (lb),
                .neg    (3'b000),
                .addend (Q_ZERO),
                .result (c_mat[3*gi + gj])
            );
        end
    end

    // trace minus three
    assign trc = sat_q(36'(c_mat[0]) + 36'(c_mat[4]) + 36'(c_mat[8]));

    always_ff @(posedge aclk) begin
        if (en) begin
            trm3_reg <= sat_q(36'(trc) - 36'(Q_THREE));
        end
    end

    // cofactors of C
    for (genvar gi = 0; gi < 3; gi++) begin : g_cof_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_cof_col
            vec3_t la;
            vec3_t lb;
            assign la[0] = c_mat[3*((gi+1)%3) + (gj+1)%3];
            assign lb[0] = c_mat[3*((gi+2)%3) + (gj+2)%3];
            assign la[1] = c_mat[3*((gi+1)%3) + (gj+2)%3];
            assign lb[1] = c_mat[3*((gi+2)%3) + (gj+1)%3];
            assign la[2] = Q_ZERO;
            assign lb[2] = Q_ZERO;
            nhse_dot_lane u_lane (
                .aclk   (aclk),
                .en     (en),
                .a      (la),
                .b      (lb),
                .neg    (3'b010),
                .addend (Q_ZERO),
                .result (cof_mat[3*gi + gj])
            );
        end
    end

    // hold row 0 of C until the cofactors arrive
    always_ff @(posedge aclk) begin
        if (en) begin
            c0_dly_reg[0] <= {c_mat[2], c_mat[1], c_mat[0]};
            for (int i = 1; i < D_C0; i++) begin
                c0_dly_reg[i] <= c0_dly_reg[i-1];
            end
        end
    end

    // determinant
    if (1'b1) begin : g_det
        vec3_t la;
        vec3_t lb;
        for (genvar k = 0; k < 3; k++) begin : g_k
            assign la[k] = q_t'(c0_dly_reg[D_C0-1][32*k +: 32]);
            assign lb[k] = cof_mat[k];
        end
        nhse_dot_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .a      (la),
            .b      (lb),
            .neg    (3'b000),
            .addend (Q_ZERO),
            .result (det)
        );
    end

    assign det_bad = det[31] || (det == Q_ZERO);

    // hold the cofactors until the determinant is ready
    always_comb begin
        for (int i = 0; i < 9; i++) begin
            cof_flat[32*i +: 32] = cof_mat[i];
            f_flat[32*i +: 32] = f_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cof_dly_reg[0] <= cof_flat;
            for (int i = 1; i < D_COF; i++) begin
                cof_dly_reg[i] <= cof_dly_reg[i-1];
            end
        end
    end

    assign cof_old = cof_dly_reg[D_COF-1];

    // carry the invalid flag to the output
    always_ff @(posedge aclk) begin
        if (en) begin
            inv_dly_reg <= {inv_dly_reg[D_INV-2:0], det_bad};
        end
    end

    // lnJ = 0.5 ln det C
    nhse_ln_unit u_ln (
        .aclk    (aclk),
        .en      (en),
        .x       (det),
        .half_ln (lnj)
    );

    // C^-1 = transposed cofactors over det, one divider per element
    for (genvar gi = 0; gi < 3; gi++) begin : g_div_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_div_col
            nhse_div_unit u_div (
                .aclk (aclk),
                .en   (en),
                .num  (q_t'(cof_old[32*(3*gj + gi) +: 32])),
                .den  (det),
                .quo  (ci_mat[3*gi + gj])
            );
        end
    end

    // pressure p = lambda * lnJ
    if (1'b1) begin : g_p
        vec3_t la;
        vec3_t lb;
        assign la[0] = lambda_q;
        assign lb[0] = lnj;
        assign la[1] = Q_ZERO;
        assign lb[1] = Q_ZERO;
        assign la[2] = Q_ZERO;
        assign lb[2] = Q_ZERO;
        nhse_dot_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .a      (la),
            .b      (lb),
            .neg    (3'b000),
            .addend (Q_ZERO),
            .result (p_val)
        );
    end

    // p - mu and p/2 - mu
    always_ff @(posedge aclk) begin
        if (en) begin
            coef_reg <= sat_q(36'(p_val) - 36'(mu_q));
            hp_mu_reg <= sat_q(36'(half_rnd(p_val)) - 36'(mu_q));
        end
    end

    // align lnJ and tr C - 3 with the coefficients
    always_ff @(posedge aclk) begin
        if (en) begin
            lnj_dly_reg[0] <= lnj;
            for (int i = 1; i < D_LN; i++) begin
                lnj_dly_reg[i] <= lnj_dly_reg[i-1];
            end
            trm3_dly_reg[0] <= trm3_reg;
            for (int i = 1; i < D_TR; i++) begin
                trm3_dly_reg[i] <= trm3_dly_reg[i-1];
            end
        end
    end

    // strain energy
    if (1'b1) begin : g_w
        vec3_t la;
        vec3_t lb;
        assign la[0] = hp_mu_reg;
        assign lb[0] = lnj_dly_reg[D_LN-1];
        assign la[1] = half_mu;
        assign lb[1] = trm3_dly_reg[D_TR-1];
        assign la[2] = Q_ZERO;
        assign lb[2] = Q_ZERO;
        nhse_dot_lane u_lane (
            .aclk   (aclk),
            .en     (en),
            .a      (la),
            .b      (lb),
            .neg    (3'b000),
            .addend (Q_ZERO),
            .result (w_val)
        );
    end

    // hold energy, coefficient and F until the stress path catches up
    always_ff @(posedge aclk) begin
        if (en) begin
            w_dly_reg[0] <= w_val;
            for (int i = 1; i < D_W; i++) begin
                w_dly_reg[i] <= w_dly_reg[i-1];
            end
            coef_dly_reg[0] <= coef_reg;
            for (int i = 1; i < D_COEF; i++) begin
                coef_dly_reg[i] <= coef_dly_reg[i-1];
            end
            f_dly_reg[0] <= f_flat;
            for (int i = 1; i < D_F; i++) begin
                f_dly_reg[i] <= f_dly_reg[i-1];
            end
        end
    end

    assign f_old = f_dly_reg[D_F-1];

    // S = (p - mu) C^-1 + mu I
    for (genvar gi = 0; gi < 3; gi++) begin : g_s_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_s_col
            vec3_t la;
            vec3_t lb;
            assign la[0] = coef_dly_reg[D_COEF-1];
            assign lb[0] = ci_mat[3*gi + gj];
            assign la[1] = Q_ZERO;
            assign lb[1] = Q_ZERO;
            assign la[2] = Q_ZERO;
            assign lb[2] = Q_ZERO;
            nhse_dot_lane u_lane (
                .aclk   (aclk),
                .en     (en),
                .a      (la),
                .b      (lb),
                .neg    (3'b000),
                .addend ((gi == gj) ? mu_q : Q_ZERO),
                .result (s_mat[3*gi + gj])
            );
        end
    end

    // P = F S
    for (genvar gi = 0; gi < 3; gi++) begin : g_pk_row
        for (genvar gj = 0; gj < 3; gj++) begin : g_pk_col
            vec3_t la;
            vec3_t lb;
            for (genvar k = 0; k < 3; k++) begin : g_k
                assign la[k] = q_t'(f_old[32*(3*gi + k) +: 32]);
                assign lb[k] = s_mat[3*k + gj];
            end
            nhse_dot_lane u_lane (
                .aclk   (aclk),
                .en     (en),
                .a      (la),
                .b      (lb),
                .neg    (3'b000),
                .addend (Q_ZERO),
                .result (p_mat[3*gi + gj])
            );
        end
    end

    // output register: merge lanes, zero on invalid
    always_ff @(posedge aclk) begin
        if (en) begin
            out_inv_reg <= inv_dly_reg[D_INV-1];
            for (int i = 0; i < 9; i++) begin
                out_data_reg[32*i +: 32] <= inv_dly_reg[D_INV-1] ? Q_ZERO : p_mat[i];
            end
            out_data_reg[319:288] <= inv_dly_reg[D_INV-1] ? Q_ZERO : w_dly_reg[D_W-1];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tuser = out_inv_reg;

`ifndef NO_ASSERTIONS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (m_tdata == '0))
        else $error("invalid word carries nonzero results");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");
`endif

endmodule

`default_nettype wire

// ----- design/nhse_dot_lane.sv -----
`default_nettype none

module nhse_dot_lane (
    input  logic            aclk,
    input  logic            en,
    input  nhse_pkg::vec3_t a,
    input  nhse_pkg::vec3_t b,
    input  logic [2:0]      neg,
    input  nhse_pkg::q_t    addend,
    output nhse_pkg::q_t    result
);
    import nhse_pkg::*;

    logic signed [63:0] prod_reg [3];
    q_t                 add_reg;
    q_t                 rnd [3];
    logic signed [35:0] acc;
    q_t                 result_reg;

    // multiply the three pairs
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                prod_reg[k] <= 64'(a[k]) * 64'(b[k]);
            end
            add_reg <= addend;
        end
    end

    // round each product, accumulate with sign, saturate
    always_comb begin
        acc = 36'(add_reg);
        for (int k = 0; k < 3; k++) begin
            rnd[k] = qmul_round(prod_reg[k]);
            if (neg[k]) begin
                acc = acc - 36'(rnd[k]);
            end else begin
                acc = acc + 36'(rnd[k]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            result_reg <= sat_q(acc);
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ----- design/nhse_ln_unit.sv -----
`default_nettype none

module nhse_ln_unit (
    input  logic         aclk,
    input  logic         en,
    input  nhse_pkg::q_t x,
    output nhse_pkg::q_t half_ln
);
    import nhse_pkg::*;

    logic [30:0]        x_reg;
    logic [4:0]         e_reg;
    logic [4:0]         e_det;
    logic [30:0]        m_reg [17];
    logic [15:0]        fr_reg [17];
    logic signed [5:0]  ei_reg [17];
    logic signed [54:0] prod_reg;
    logic [54:0]        mag;
    logic [54:0]        mag_rnd;
    logic               neg;
    q_t                 ln_reg;

    // find the top set bit
    always_comb begin
        e_det = 5'd0;
        for (int i = 0; i < 31; i++) begin
            if (x[i]) begin
                e_det = 5'(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x[30:0];
            e_reg <= e_det;
        end
    end

    // normalize the mantissa to Q1.30 in [1, 2)
    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0]  <= 31'(x_reg << (5'd30 - e_reg));
            fr_reg[0] <= '0;
            ei_reg[0] <= $signed({1'b0, e_reg}) - 6'sd16;
        end
    end

    // one fraction bit per squaring step
    for (genvar j = 0; j < 16; j++) begin : g_sq
        logic [61:0] sq;
        logic [31:0] t;

        always_comb begin
            sq = 62'(m_reg[j]) * 62'(m_reg[j]);
            t = sq[61:30];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                m_reg[j+1]  <= t[31] ? t[31:1] : t[30:0];
                fr_reg[j+1] <= {fr_reg[j][14:0], t[31]};
                ei_reg[j+1] <= ei_reg[j];
            end
        end
    end

    // scale log2 by ln 2
    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= 55'($signed({ei_reg[16], fr_reg[16]})) * $signed({22'd0, LN2_Q32});
        end
    end

    // divide by 2^33 with rounding, which also halves
    always_comb begin
        neg = prod_reg[54];
        mag = neg ? 55'(-prod_reg) : 55'(prod_reg);
        mag_rnd = mag + 55'h1_0000_0000;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ln_reg <= neg ? q_t'(32'd0 - 32'(mag_rnd[54:33])) : q_t'(32'(mag_rnd[54:33]));
        end
    end

    assign half_ln = ln_reg;

endmodule

`default_nettype wire

// ----- design/nhse_div_unit.sv -----
`default_nettype none

module nhse_div_unit (
    input  logic         aclk,
    input  logic         en,
    input  nhse_pkg::q_t num,
    input  nhse_pkg::q_t den,
    output nhse_pkg::q_t quo
);
    import nhse_pkg::*;

    typedef struct packed {
        logic [30:0] rem;
        logic [31:0] low;
        logic [30:0] dv;
        logic        neg;
        logic        ovf;
        logic [31:0] q;
    } div_stage_t;

    div_stage_t  st_reg [33];
    logic [31:0] mag;
    logic [47:0] dividend;
    logic [31:0] q_last;
    q_t          quo_reg;

    // scale the numerator, add half the divisor for rounding
    always_comb begin
        mag = num[31] ? 32'd0 - 32'(num) : 32'(num);
        dividend = {mag, 16'd0} + 48'(den[30:1]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0].rem <= 31'(dividend[47:32]);
            st_reg[0].low <= dividend[31:0];
            st_reg[0].dv  <= den[30:0];
            st_reg[0].neg <= num[31];
            st_reg[0].ovf <= 31'(dividend[47:32]) >= den[30:0];
            st_reg[0].q   <= '0;
        end
    end

    // restoring division, one quotient bit per step
    for (genvar s = 0; s < 32; s++) begin : g_step
        logic [31:0] r2;
        logic        ge;

        always_comb begin
            r2 = {st_reg[s].rem, st_reg[s].low[31]};
            ge = r2 >= {1'b0, st_reg[s].dv};
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[s+1].rem <= ge ? 31'(r2 - {1'b0, st_reg[s].dv}) : r2[30:0];
                st_reg[s+1].low <= {st_reg[s].low[30:0], 1'b0};
                st_reg[s+1].dv  <= st_reg[s].dv;
                st_reg[s+1].neg <= st_reg[s].neg;
                st_reg[s+1].ovf <= st_reg[s].ovf;
                st_reg[s+1].q   <= {st_reg[s].q[30:0], ge};
            end
        end
    end

    // apply sign and saturate
    assign q_last = st_reg[32].q;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (st_reg[32].ovf) begin
                quo_reg <= st_reg[32].neg ? Q_MIN : Q_MAX;
            end else if (st_reg[32].neg) begin
                quo_reg <= (q_last > 32'h8000_0000) ? Q_MIN : q_t'(32'd0 - q_last);
            end else begin
                quo_reg <= q_last[31] ? Q_MAX : q_t'(q_last);
            end
        end
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

// ----- sim/neohookean_stress_energy_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none

module neohookean_stress_energy_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [287:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [319:0] m_tdata,
    input  logic         m_tuser,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [30:0]  cfg_wr_data,
    output int           fail_count,
    output int           pending_count
);
    import nhse_pkg::*;

    typedef struct {
        logic [319:0] stress_energy;
        logic         invalid;
    } piola_result_t;

    piola_result_t expected_piola_q[$];
    longint        lambda_q;
    longint        mu_q;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint shr_round(input longint v, input int s);
        longint unsigned mag;
        mag = v < 0 ? longint'(0) - v : v;
        mag = (mag + (longint'(1) << (s - 1))) >> s;
        return v < 0 ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        return clamp32(shr_round(a * b, 16));
    endfunction

    function automatic longint fx_div(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = num < 0 ? longint'(0) - num : num;
        q = ((mag << 16) + den / 2) / den;
        return clamp32(num < 0 ? -longint'(q) : longint'(q));
    endfunction

    // 0.5*ln(x) by squaring log2, then scale by ln 2
    function automatic longint half_log(input longint x);
        int              e;
        longint unsigned m;
        longint          l2;
        e = 30;
        while (e > 0 && ((x >> e) & 1) == 0) e--;
        m = longint'(x) << (30 - e);
        l2 = longint'(e - 16) * 65536;
        for (int i = 15; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= (longint'(1) << 31)) begin
                m = m >> 1;
                l2 += longint'(1) << i;
            end
        end
        return clamp32(shr_round(l2 * longint'(LN2_Q32), 33));
    endfunction

    function automatic piola_result_t predict_piola(input logic [287:0] word);
        longint        f[3][3], c[3][3], cof[3][3], s[3][3];
        longint        det, lnj, p, coef, trc, w, acc;
        piola_result_t r;
        for (int i = 0; i < 9; i++) f[i / 3][i % 3] = longint'($signed(word[32 * i +: 32]));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += fx_mul(f[k][i], f[k][j]);
                c[i][j] = clamp32(acc);
            end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cof[i][j] = clamp32(
                    fx_mul(c[(i + 1) % 3][(j + 1) % 3], c[(i + 2) % 3][(j + 2) % 3])
                    - fx_mul(c[(i + 1) % 3][(j + 2) % 3], c[(i + 2) % 3][(j + 1) % 3]));
        det = clamp32(fx_mul(c[0][0], cof[0][0]) + fx_mul(c[0][1], cof[0][1])
                      + fx_mul(c[0][2], cof[0][2]));
        r.stress_energy = '0;
        r.invalid = 1'b1;
        if (det <= 0) return r;
        lnj = half_log(det);
        p = fx_mul(lambda_q, lnj);
        coef = clamp32(p - mu_q);
        trc = clamp32(c[0][0] + c[1][1] + c[2][2]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                s[i][j] = clamp32(fx_mul(coef, fx_div(cof[j][i], det)) + (i == j ? mu_q : 0));
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += fx_mul(f[i][k], s[k][j]);
                r.stress_energy[32 * (3 * i + j) +: 32] = 32'(clamp32(acc));
            end
        w = clamp32(fx_mul(clamp32(shr_round(p, 1) - mu_q), lnj)
                    + fx_mul(shr_round(mu_q, 1), clamp32(trc - 3 * 65536)));
        r.stress_energy[288 +: 32] = 32'(w);
        r.invalid = 1'b0;
        return r;
    endfunction

    // track registers, queue predictions, compare results
    always @(posedge aclk) begin
        piola_result_t exp_r;
        if (!aresetn) begin
            lambda_q = 65536;
            mu_q = 65536;
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == REG_LAME_LAMBDA) lambda_q = cfg_wr_data;
                else if (cfg_index == REG_SHEAR_MODULUS) mu_q = cfg_wr_data;
            end
            if (s_tvalid && s_tready) expected_piola_q.push_back(predict_piola(s_tdata));
            if (m_tvalid && m_tready) begin
                if (expected_piola_q.size() == 0) begin
                    $display("%0t: unexpected word %h invalid %b", $time, m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    exp_r = expected_piola_q.pop_front();
                    for (int i = 0; i < 10; i++)
                        if (m_tdata[32 * i +: 32] !== exp_r.stress_energy[32 * i +: 32]) begin
                            $display("%0t: field %0d expected %h actual %h", $time, i,
                                     exp_r.stress_energy[32 * i +: 32], m_tdata[32 * i +: 32]);
                            fail_count++;
                        end
                    if (m_tuser !== exp_r.invalid) begin
                        $display("%0t: invalid expected %b actual %b", $time,
                                 exp_r.invalid, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
        pending_count = expected_piola_q.size();
    end

endmodule

`default_nettype wire

// ----- sim/neohookean_stress_energy_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none

module neohookean_stress_energy_tb;
    import nhse_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [287:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic         m_tuser;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [30:0]  cfg_wr_data;
    int           fail_count;
    int           pending_count;
    int           stall_pct;
    int           idle_pct;
    logic         hold_off;

    neohookean_stress_energy i_dut (.*);

    neohookean_stress_energy_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("neohookean_stress_energy_tb: done, errors");
        $finish;
    end

    // receiver: random stall, or a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_off) m_tready <= 1'b0;
        else m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [31:0] q_of(input real v);
        return 32'($rtoi(v * 65536.0));
    endfunction

    // diagonal stretch with small shear
    function automatic logic [287:0] gradient_word(input real a, input real b, input real c,
                                                   input real sh);
        logic [287:0] w;
        w = '0;
        w[0 +: 32] = q_of(a);
        w[128 +: 32] = q_of(b);
        w[256 +: 32] = q_of(c);
        w[32 +: 32] = q_of(sh);
        w[224 +: 32] = q_of(-sh);
        return w;
    endfunction

    function automatic logic [287:0] random_gradient();
        logic [287:0] w;
        int k;
        k = $urandom_range(99);
        if (k < 10) begin
            for (int i = 0; i < 9; i++) w[32 * i +: 32] = $urandom;
        end else if (k < 20) begin
            for (int i = 0; i < 9; i++) w[32 * i +: 32] = $urandom_range(1) ? 32'h7fffffff
                                                                               : 32'h80000000;
        end else begin
            for (int i = 0; i < 9; i++)
                w[32 * i +: 32] = 32'($signed($urandom_range(131072)) - 65536);
            for (int i = 0; i < 3; i++)
                w[128 * i +: 32] = 32'h10000 + 32'($urandom_range(98304)) - 32'd32768;
        end
        return w;
    endfunction

    // offer one word; valid stays up so the next word can follow at once
    task automatic send_word(input logic [287:0] w);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain_and_idle();
        s_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        logic [287:0] w;
        logic [30:0]  lam_set[5];
        logic [30:0]  mu_set[5];
        lam_set = '{31'h10000, 31'h0, 31'h7fffffff, 31'h28000, 31'h4000};
        mu_set = '{31'h10000, 31'h7fffffff, 31'h0, 31'h8000, 31'h30000};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        stall_pct = 0;
        idle_pct = 0;
        hold_off = 1'b0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: identity, stretch, compression, singular, reflection, extremes
        send_word(gradient_word(1.0, 1.0, 1.0, 0.0));
        send_word(gradient_word(2.0, 1.0, 0.5, 0.25));
        send_word(gradient_word(0.5, 0.5, 0.5, 0.0));
        send_word(gradient_word(3.0, 2.5, 4.0, 1.0));
        send_word(gradient_word(1.0, 0.0, 1.0, 0.0));
        send_word(gradient_word(-1.0, 1.0, 1.0, 0.0));
        send_word('0);
        send_word({9{32'h7fffffff}});
        send_word({9{32'h80000000}});
        send_word({9{32'hffffffff}});
        send_word(gradient_word(0.01, 0.01, 0.01, 0.0));
        send_word(gradient_word(100.0, 100.0, 100.0, 0.0));
        send_word(gradient_word(1.1, 0.9, 1.0, 0.3));
        drain_and_idle();
        write_reg(2'd2, 31'h1234);
        write_reg(2'd3, 31'h4321);
        send_word(gradient_word(1.5, 1.0, 1.0, 0.0));

        // random phases over register settings and stall and idling mixes
        for (int ph = 0; ph < 5; ph++) begin
            drain_and_idle();
            write_reg(REG_LAME_LAMBDA, lam_set[ph] == 31'h4000 ? 31'($urandom) : lam_set[ph]);
            write_reg(REG_SHEAR_MODULUS, mu_set[ph]);
            case (ph % 4)
                0: begin stall_pct = 0;  idle_pct = 0;  end
                1: begin stall_pct = 0;  idle_pct = 71; end
                2: begin stall_pct = 71; idle_pct = 0;  end
                default: begin stall_pct = 17; idle_pct = 17; end
            endcase
            for (int n = 0; n < 220; n++) begin
                if (ph == 0 && n == 50) hold_off = 1'b1;
                send_word(random_gradient());
            end
            hold_off = 1'b0;
        end

        // pause until all results are in, then finish
        drain_and_idle();
        if (fail_count == 0) begin
            $display("neohookean_stress_energy_tb: done, clean");
        end else begin
            $display("neohookean_stress_energy_tb: done, errors");
        end
        $finish;
    end

    // release the long hold-off after a fixed count of cycles
    initial begin
        int cnt;
        cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                cnt++;
                if (cnt == 300) hold_off = 1'b0;
            end else begin
                cnt = 0;
            end
        end
    end

endmodule

`default_nettype wire
